// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLRG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/slrg_pkg.sv =====
// Types, constants and arithmetic helpers of the shuffled Lehmer generator.
package slrg_pkg;

  // Lehmer multiplier and Mersenne modulus 2^31-1.
  localparam logic [14:0] LEHMER_MUL = 15'd16807;
  localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;

  typedef logic [30:0] value_t;

  typedef enum logic {
    ST_SEED,
    ST_RUN
  } state_e;

  typedef enum logic {
    CMD_NEXT = 1'b0,
    CMD_SEED = 1'b1
  } cmd_e;

  // One Lehmer step: (op * 16807) mod (2^31-1) for op up to 2^31.
  // The product is folded once at bit 31 and corrected by one subtract.
  function automatic value_t lehmer_step(input logic [31:0] op);
    logic [46:0] prod;
    logic [31:0] fold;
    prod = 47'(op) * 47'(LEHMER_MUL);
    fold = {1'b0, prod[30:0]} + {16'b0, prod[46:31]};
    if (fold >= {1'b0, LEHMER_MOD}) begin
      fold = fold - {1'b0, LEHMER_MOD};
    end
    return fold[30:0];
  endfunction

  // Seed conditioning: zero or negative seeds use their magnitude, floor 1.
  function automatic logic [31:0] seed_magnitude(input logic [31:0] raw);
    logic [31:0] mag;
    if (raw[31]) begin
      mag = 32'd0 - raw;
    end else if (raw == 32'd0) begin
      mag = 32'd1;
    end else begin
      mag = raw;
    end
    return mag;
  endfunction

endpackage

// ===== sv/slrg_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module slrg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/shuffled_lehmer_random_generator_top.sv =====
// Shuffled Lehmer random generator (minimal standard generator with a shuffle table).
// A next transfer (tuser low) advances the Lehmer state, swaps it into the shuffle
// table slot picked by the previous output, and returns the old slot contents; a
// reseed transfer (tuser high) reloads state and table and returns nothing. Next
// transfers are taken one per clock while the output side drains, and each result
// passes through the table RAM read register and then the output register to the
// master side. The slot of the following read is derived from the RAM read data in
// the same cycle, so that loop sets the clock.
// After a reseed transfer s_axis_tready stays low through a warm-up in which the
// Lehmer state advances at every step and refills the table; the same warm-up,
// seeded with 1, runs right after reset.
module shuffled_lehmer_random_generator_top #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value (signed)
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] random_value, [31] zero
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 8);
  localparam int SLOT_DIV = 1 + 2147483646 / TABLE_ENTRIES;

  slrg_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  slrg_pkg::value_t lehmer_q, lehmer_d;
  slrg_pkg::value_t last_q, last_d;
  logic             pend_q, pend_d;
  logic             oval_q, oval_d;
  slrg_pkg::value_t odata_q, odata_d;

  logic             in_xfer;
  logic             is_seed;
  logic             move;
  slrg_pkg::value_t last_cur;
  logic [IDX_W-1:0] slot_cur;
  logic [31:0]      step_op;
  slrg_pkg::value_t step_val;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  slrg_pkg::value_t ram_rdata;

  // Shuffle table storage.
  slrg_ram #(
    .WIDTH($bits(slrg_pkg::value_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(step_val),
    .re_i   (ram_re),
    .raddr_i(slot_cur),
    .rdata_o(ram_rdata)
  );

  // Handshake. A pending read result must leave the RAM output before a new transfer.
  assign move          = pend_q & (~oval_q | m_axis_tready);
  assign s_axis_tready = (state_q == slrg_pkg::ST_RUN) & (~pend_q | move);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign is_seed       = (s_axis_tuser == slrg_pkg::CMD_SEED);

  // The previous output is still in the RAM read register until it moves on.
  assign last_cur = pend_q ? ram_rdata : last_q;

  // Slot = last_cur / SLOT_DIV, found by comparing against constant thresholds.
  always_comb begin
    slot_cur = '0;
    for (int k = 1; k < TABLE_ENTRIES; k++) begin
      if ({1'b0, last_cur} >= 32'(k * SLOT_DIV)) begin
        slot_cur = IDX_W'(k);
      end
    end
  end

  // The single Lehmer step unit, fed by the seed on a reseed transfer.
  assign step_op  = (state_q == slrg_pkg::ST_RUN && in_xfer && is_seed) ?
                    slrg_pkg::seed_magnitude(s_axis_tdata) : {1'b0, lehmer_q};
  assign step_val = slrg_pkg::lehmer_step(step_op);

  // Sequencer: next value service and table reload.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lehmer_d  = lehmer_q;
    pend_d    = pend_q & ~move;
    last_d    = move ? ram_rdata : last_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_cur;
    case (state_q)
      slrg_pkg::ST_RUN: begin
        if (in_xfer) begin
          lehmer_d = step_val;
          if (is_seed) begin
            state_d = slrg_pkg::ST_SEED;
            cnt_d   = CNT_W'(TABLE_ENTRIES + 6);
          end else begin
            // Read the old entry and write the new state to the same slot.
            ram_we = 1'b1;
            ram_re = 1'b1;
            pend_d = 1'b1;
          end
        end
      end
      slrg_pkg::ST_SEED: begin
        lehmer_d = step_val;
        if (cnt_q < CNT_W'(TABLE_ENTRIES)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[IDX_W-1:0];
        end
        if (cnt_q == '0) begin
          state_d = slrg_pkg::ST_RUN;
          last_d  = step_val;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        state_d = slrg_pkg::ST_SEED;
      end
    endcase
  end

  // Output register.
  always_comb begin
    oval_d  = move | (oval_q & ~m_axis_tready);
    odata_d = move ? ram_rdata : odata_q;
  end

  // Control state; reset starts the warm-up from seed 1, one step already taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= slrg_pkg::ST_SEED;
      cnt_q    <= CNT_W'(TABLE_ENTRIES + 6);
      lehmer_q <= slrg_pkg::value_t'(slrg_pkg::LEHMER_MUL);
      pend_q   <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lehmer_q <= lehmer_d;
      pend_q   <= pend_d;
      oval_q   <= oval_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {1'b0, odata_q};

endmodule

// ===== sv/slrg_checker.sv =====
// Port-level checker for the shuffled Lehmer generator, bound to the top level.
`include "assert_macros.svh"

module slrg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result holds its value.
  `SLRG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

  // A reseed transfer is followed by warm-up with no input transfers.
  `SLRG_ASSERT_NEXT(a_seed_busy, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tuser,
    !s_axis_tready,
    "input ready right after a reseed")

  // A fresh result traces back to a next transfer, through the RAM read and output registers.
  `SLRG_ASSERT_NOW(a_out_origin, clk_i, rst_ni,
    $rose(m_axis_tvalid),
    $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser, 2),
    "result without a next transfer")

  // Results never reach the modulus and never use the top bit.
  `SLRG_ASSERT_NOW(a_out_range, clk_i, rst_ni,
    m_axis_tvalid,
    !m_axis_tdata[31] && (m_axis_tdata[30:0] != 31'h7FFF_FFFF),
    "result out of range")

endmodule

bind shuffled_lehmer_random_generator_top slrg_checker u_slrg_checker (.*);
